// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hw/rtl/bsp_pkg.sv =====
package bsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VTX_W        = 6;
    localparam int LEN_W        = 7;
    localparam int EADR_W       = 8;
    localparam int ECNT_W       = 9;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] ST_VERTEX    = 3'd0;
    localparam logic [2:0] ST_BADV      = 3'd1;
    localparam logic [2:0] ST_NOPATH    = 3'd2;
    localparam logic [2:0] ST_NOTMULT   = 3'd3;
    localparam logic [2:0] ST_BADSTRIDE = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] node_a;
        logic [5:0] node_b;
        logic [6:0] stride;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] path_length;
        logic [5:0] path_vertex;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       latch_item;
        logic       edge_clear;
        logic       edge_add;
        logic       clr_start;
        logic       clr_step;
        logic       init_q;
        logic       deq_rd;
        logic       e_rst;
        logic       edge_rd;
        logic       e_inc;
        logic       vis_rd;
        logic       visit_wr;
        logic       walk_start;
        logic       walk_step;
        logic       walk_load;
        logic       mod_start;
        logic       mod_step;
        logic       emit_start;
        logic       emit_rd;
        logic       emit_adv;
        logic       out_load;
        logic [2:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad_vertex;
        logic       stride_zero;
        logic       full;
        logic       clr_done;
        logic       queue_empty;
        logic       u_is_dst;
        logic       edge_done;
        logic       cand_ok;
        logic       vis_free;
        logic       walk_done;
        logic       mod_ge;
        logic       mod_zero;
        logic       emit_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== hw/rtl/bsp_dp.sv =====
module bsp_dp
    import bsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      cfg_we,
    input  logic [6:0] cfg_data,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [1:0]        op_reg;
    logic [VTX_W-1:0]  a_reg;
    logic [VTX_W-1:0]  b_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [6:0]        vcount_reg;
    logic [ECNT_W-1:0] edge_total_reg;
    logic [ECNT_W-1:0] e_reg;
    logic [VTX_W-1:0]  clr_reg;
    logic [LEN_W-1:0]  head_reg;
    logic [LEN_W-1:0]  tail_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [VTX_W-1:0]  cur_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [7:0]        emit_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [11:0]              edge_mem [MAX_EDGES];
    logic                     vis_mem  [MAX_VERTICES];
    logic [VTX_W-1:0]         par_mem  [MAX_VERTICES];
    logic [LEN_W+VTX_W-1:0]   q_mem    [MAX_VERTICES];
    logic [VTX_W-1:0]         pb_mem   [MAX_VERTICES];

    logic [11:0]              edge_q;
    logic                     vis_q;
    logic [VTX_W-1:0]         par_q;
    logic [LEN_W+VTX_W-1:0]   q_q;
    logic [VTX_W-1:0]         pb_q;

    logic [6:0]        live_n;
    logic [VTX_W-1:0]  u;
    logic [LEN_W-1:0]  hop_u;
    logic [VTX_W-1:0]  ea;
    logic [VTX_W-1:0]  eb;
    logic              match_a;
    logic [VTX_W-1:0]  cand;
    logic [LEN_W-1:0]  idx_m1;
    logic              out_free;

    assign live_n  = (vcount_reg == 7'd0) ? 7'd1 :
                     (vcount_reg > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_reg;
    assign u       = q_q[VTX_W-1:0];
    assign hop_u   = q_q[LEN_W+VTX_W-1:VTX_W];
    assign ea      = edge_q[5:0];
    assign eb      = edge_q[11:6];
    assign match_a = (ea == u);
    assign cand    = match_a ? eb : ea;
    assign idx_m1  = idx_reg - 7'd1;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.op          = op_reg;
        sts.bad_vertex  = ({1'b0, a_reg} >= live_n) || ({1'b0, b_reg} >= live_n);
        sts.stride_zero = (k_reg == 7'd0);
        sts.full        = (edge_total_reg >= 9'(MAX_EDGES));
        sts.clr_done    = (clr_reg == 6'(MAX_VERTICES - 1));
        sts.queue_empty = (head_reg == tail_reg);
        sts.u_is_dst    = (u == b_reg);
        sts.edge_done   = (e_reg >= edge_total_reg);
        sts.cand_ok     = (match_a || (eb == u)) && ({1'b0, cand} < live_n);
        sts.vis_free    = !vis_q && (tail_reg < 7'(MAX_VERTICES));
        sts.walk_done   = (idx_reg == 7'd0);
        sts.mod_ge      = (rem_reg >= k_reg);
        sts.mod_zero    = (rem_reg == 7'd0);
        sts.emit_last   = ((emit_reg + {1'b0, k_reg}) >= {1'b0, len_reg});
        sts.out_free    = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= 7'(MAX_VERTICES);
            edge_total_reg <= '0;
            e_reg          <= '0;
            clr_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vcount_reg <= cfg_data;
            if (cmd.edge_clear)
                edge_total_reg <= '0;
            else if (cmd.edge_add)
                edge_total_reg <= edge_total_reg + 9'd1;
            if (cmd.e_rst)
                e_reg <= '0;
            else if (cmd.e_inc)
                e_reg <= e_reg + 9'd1;
            if (cmd.clr_start)
                clr_reg <= '0;
            else if (cmd.clr_step)
                clr_reg <= clr_reg + 6'd1;
            if (cmd.init_q)
            begin
                head_reg <= '0;
                tail_reg <= 7'd1;
            end
            else
            begin
                if (cmd.deq_rd)
                    head_reg <= head_reg + 7'd1;
                if (cmd.visit_wr)
                    tail_reg <= tail_reg + 7'd1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg <= in_item.operation;
            a_reg  <= in_item.node_a;
            b_reg  <= in_item.node_b;
            k_reg  <= in_item.stride;
        end
        if (cmd.walk_start)
        begin
            len_reg <= hop_u + 7'd1;
            idx_reg <= hop_u + 7'd1;
            cur_reg <= b_reg;
        end
        else
        begin
            if (cmd.walk_step)
                idx_reg <= idx_m1;
            if (cmd.walk_load)
                cur_reg <= par_q;
        end
        if (cmd.mod_start)
            rem_reg <= len_reg;
        else if (cmd.mod_step)
            rem_reg <= rem_reg - k_reg;
        if (cmd.emit_start)
            emit_reg <= '0;
        else if (cmd.emit_adv)
            emit_reg <= emit_reg + {1'b0, k_reg};
        if (cmd.out_load)
        begin
            out_reg.status      <= cmd.out_status;
            out_reg.path_length <= (cmd.out_status == ST_VERTEX ||
                                    cmd.out_status == ST_NOTMULT) ? len_reg : 7'd0;
            out_reg.path_vertex <= (cmd.out_status == ST_VERTEX) ? pb_q : 6'd0;
            out_reg.last        <= (cmd.out_status == ST_VERTEX) ? sts.emit_last : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_add)
            edge_mem[edge_total_reg[EADR_W-1:0]] <= {b_reg, a_reg};
        if (cmd.edge_rd)
            edge_q <= edge_mem[e_reg[EADR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            vis_mem[clr_reg] <= 1'b0;
        else if (cmd.init_q)
            vis_mem[a_reg] <= 1'b1;
        else if (cmd.visit_wr)
            vis_mem[cand] <= 1'b1;
        if (cmd.vis_rd)
            vis_q <= vis_mem[cand];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_q)
            par_mem[a_reg] <= a_reg;
        else if (cmd.visit_wr)
            par_mem[cand] <= u;
        if (cmd.walk_step)
            par_q <= par_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_q)
            q_mem[0] <= {7'd0, a_reg};
        else if (cmd.visit_wr)
            q_mem[tail_reg[VTX_W-1:0]] <= {hop_u + 7'd1, cand};
        if (cmd.deq_rd)
            q_q <= q_mem[head_reg[VTX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
            pb_mem[idx_m1[VTX_W-1:0]] <= cur_reg;
        if (cmd.emit_rd)
            pb_q <= pb_mem[emit_reg[VTX_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== hw/rtl/bsp_ctrl.sv =====
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_CLEAR   = 4'd2;
    localparam logic [3:0] S_INIT    = 4'd3;
    localparam logic [3:0] S_DEQ     = 4'd4;
    localparam logic [3:0] S_DEQ_CHK = 4'd5;
    localparam logic [3:0] S_EDGE_RD = 4'd6;
    localparam logic [3:0] S_EDGE_CK = 4'd7;
    localparam logic [3:0] S_VIS_CK  = 4'd8;
    localparam logic [3:0] S_NOPATH  = 4'd9;
    localparam logic [3:0] S_WALK    = 4'd10;
    localparam logic [3:0] S_WALK_LD = 4'd11;
    localparam logic [3:0] S_MOD     = 4'd12;
    localparam logic [3:0] S_NOTMULT = 4'd13;
    localparam logic [3:0] S_EM_RD   = 4'd14;
    localparam logic [3:0] S_EM_OUT  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.edge_clear = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_DONE;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_ADD:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                            priority if (sts.bad_vertex)
                                cmd.out_status = ST_BADV;
                            else if (sts.full)
                                cmd.out_status = ST_FULL;
                            else
                            begin
                                cmd.edge_add   = 1'b1;
                                cmd.out_status = ST_DONE;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        priority if (sts.bad_vertex || sts.stride_zero)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = sts.bad_vertex ? ST_BADV : ST_BADSTRIDE;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    end
                    OP_NONE:
                        state_next = S_IDLE;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init_q = 1'b1;
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                if (sts.queue_empty)
                    state_next = S_NOPATH;
                else
                begin
                    cmd.deq_rd = 1'b1;
                    state_next = S_DEQ_CHK;
                end
            end
            S_DEQ_CHK:
            begin
                if (sts.u_is_dst)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    cmd.e_rst  = 1'b1;
                    state_next = S_EDGE_RD;
                end
            end
            S_EDGE_RD:
            begin
                if (sts.edge_done)
                    state_next = S_DEQ;
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_EDGE_CK;
                end
            end
            S_EDGE_CK:
            begin
                cmd.e_inc = 1'b1;
                if (sts.cand_ok)
                begin
                    cmd.vis_rd = 1'b1;
                    state_next = S_VIS_CK;
                end
                else
                    state_next = S_EDGE_RD;
            end
            S_VIS_CK:
            begin
                cmd.visit_wr = sts.vis_free;
                state_next   = S_EDGE_RD;
            end
            S_NOPATH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_NOPATH;
                    state_next     = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK_LD;
                end
            end
            S_WALK_LD:
            begin
                cmd.walk_load = 1'b1;
                state_next    = S_WALK;
            end
            S_MOD:
            begin
                priority if (sts.mod_ge)
                    cmd.mod_step = 1'b1;
                else if (sts.mod_zero)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EM_RD;
                end
                else
                    state_next = S_NOTMULT;
            end
            S_NOTMULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_NOTMULT;
                    state_next     = S_IDLE;
                end
            end
            S_EM_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_VERTEX;
                    cmd.emit_adv   = 1'b1;
                    state_next     = sts.emit_last ? S_IDLE : S_EM_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/bfs_shortest_path_stride_top.sv =====
// channel  | handshake           | payload
// in       | in_valid, in_stall  | in_item (in_item_t)
// out      | out_valid, out_stall| out_item (out_item_t)
// cfg      | cfg_we              | cfg_data (vertex_count)
// Clear and add finish in the decode state once the output is free; a bad
// query likewise. A query clears every visit mark, then per dequeued vertex
// scans every stored edge, then walks the path back vertex by vertex, makes
// up to 64 stride subtractions, and emits each item; the edge scan dominates.
// Reset clears control state and sets vertex_count to 64; in_stall is high
// whenever an item is in work, and a stalled out_item holds.
`include "assert_macros.svh"

module bfs_shortest_path_stride_top
    import bsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    bsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    `CHK_SAME(a_load_free, cmd.out_load, sts.out_free)
    `CHK_SAME(a_add_room, cmd.edge_add, !sts.full && !sts.bad_vertex)
    `CHK_SAME(a_enq_room, cmd.visit_wr, sts.vis_free)
    `CHK_NEXT(a_busy, in_valid && !in_stall, in_stall)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import bsp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES  = 50;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;

    in_item_t  queued_requests[$];
    out_item_t pending_replies[$];

    logic [11:0] edge_list[MAX_EDGES];
    int          edge_count;
    int          vertex_reg;
    int          error_count;

    int burst_left;
    int gap_left;
    int stall_run;
    bit stall_level;
    int idle_cycles;

    bfs_shortest_path_stride_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int live_vertices();
        int n;
        n = vertex_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        return n;
    endfunction

    function automatic void push_reply(logic [2:0] st, int len, int vtx, bit lst);
        out_item_t r;
        r.status      = st;
        r.path_length = len[6:0];
        r.path_vertex = vtx[5:0];
        r.last        = lst;
        pending_replies = {pending_replies, r};
    endfunction

    function automatic void compute_path_reply(in_item_t it);
        int n;
        int a;
        int b;
        int k;
        int mark[MAX_VERTICES];
        int hop[MAX_VERTICES];
        int par[MAX_VERTICES];
        int fifo[MAX_VERTICES];
        int route[MAX_VERTICES];
        int head;
        int tail;
        int u;
        int v;
        int ea;
        int eb;
        int len;
        int cur;
        n = live_vertices();
        a = it.node_a;
        b = it.node_b;
        k = it.stride;
        case (it.operation)
            OP_CLEAR:
            begin
                edge_count = 0;
                push_reply(ST_DONE, 0, 0, 1'b1);
            end
            OP_ADD:
            begin
                if (a >= n || b >= n)
                    push_reply(ST_BADV, 0, 0, 1'b1);
                else if (edge_count >= MAX_EDGES)
                    push_reply(ST_FULL, 0, 0, 1'b1);
                else
                begin
                    edge_list[edge_count] = {b[5:0], a[5:0]};
                    edge_count++;
                    push_reply(ST_DONE, 0, 0, 1'b1);
                end
            end
            OP_QUERY:
            begin
                if (a >= n || b >= n)
                    push_reply(ST_BADV, 0, 0, 1'b1);
                else if (k == 0)
                    push_reply(ST_BADSTRIDE, 0, 0, 1'b1);
                else
                begin
                    for (int i = 0; i < MAX_VERTICES; i++)
                        mark[i] = 0;
                    mark[a] = 1;
                    hop[a]  = 0;
                    par[a]  = a;
                    head    = 0;
                    tail    = 1;
                    fifo[0] = a;
                    while (head < tail)
                    begin
                        u = fifo[head];
                        head++;
                        if (u == b)
                            break;
                        for (int e = 0; e < edge_count; e++)
                        begin
                            ea = edge_list[e][5:0];
                            eb = edge_list[e][11:6];
                            for (int side = 0; side < 2; side++)
                            begin
                                if (side == 0 && ea != u)
                                    continue;
                                if (side == 1 && eb != u)
                                    continue;
                                v = (side == 0) ? eb : ea;
                                if (v >= n)
                                    continue;
                                if (mark[v] == 0 && tail < MAX_VERTICES)
                                begin
                                    mark[v] = 1;
                                    hop[v]  = (hop[u] + 1) & 8'hff;
                                    par[v]  = u;
                                    fifo[tail] = v;
                                    tail++;
                                end
                            end
                        end
                        mark[u] = 2;
                    end
                    if (mark[b] == 0)
                        push_reply(ST_NOPATH, 0, 0, 1'b1);
                    else
                    begin
                        len = hop[b] + 1;
                        if (len > MAX_VERTICES)
                            len = MAX_VERTICES;
                        cur = b;
                        for (int i = len; i > 0; i--)
                        begin
                            route[i - 1] = cur;
                            cur = par[cur & 63] & 63;
                        end
                        if (len % k != 0)
                            push_reply(ST_NOTMULT, len, 0, 1'b1);
                        else
                            for (int i = 0; i < len; i += k)
                                push_reply(ST_VERTEX, len, route[i], (i + k >= len));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // driver: bursts with random gaps, hold payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                compute_path_reply(in_item);
                void'(queued_requests.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_item  <= queued_requests[0];
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
            stall_level = 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_run   = $urandom_range(1, 30);
                stall_level = ($urandom_range(0, 2) == 0);
            end
            stall_run--;
            out_stall <= stall_level;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result item status %0d", out_item.status);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (out_item.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_item.status);
                    error_count++;
                end
                if (out_item.path_length !== want.path_length)
                begin
                    $error("path_length expected %0d actual %0d",
                           want.path_length, out_item.path_length);
                    error_count++;
                end
                if (out_item.path_vertex !== want.path_vertex)
                begin
                    $error("path_vertex expected %0d actual %0d",
                           want.path_vertex, out_item.path_vertex);
                    error_count++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, out_item.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bfs_shortest_path_stride_top test failed");
                $finish;
            end
        end
    end

    task automatic req(logic [1:0] op, int a, int b, int k);
        in_item_t it;
        it.operation = op;
        it.node_a    = a[5:0];
        it.node_b    = b[5:0];
        it.stride    = k[6:0];
        queued_requests = {queued_requests, it};
    endtask

    task automatic drain();
        while (queued_requests.size() > 0 || pending_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertex_count(int v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[6:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        vertex_reg = v;
    endtask

    initial
    begin
        int sent;
        int n;
        int span;
        int ne;
        int nq;
        int pick;
        edge_count  = 0;
        vertex_reg  = 64;
        error_count = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        req(OP_CLEAR, 0, 0, 0);
        req(OP_QUERY, 0, 0, 1);
        req(OP_ADD, 0, 63, 0);
        req(OP_ADD, 63, 5, 127);
        req(OP_ADD, 7, 7, 0);
        req(OP_QUERY, 0, 5, 1);
        req(OP_QUERY, 0, 5, 3);
        req(OP_QUERY, 0, 5, 2);
        req(OP_QUERY, 5, 0, 64);
        req(OP_QUERY, 63, 63, 64);
        req(OP_QUERY, 0, 5, 0);
        req(OP_QUERY, 7, 9, 1);
        req(OP_NONE, 63, 63, 127);
        req(OP_QUERY, 5, 0, 127);
        drain();

        set_vertex_count(10);
        req(OP_QUERY, 0, 5, 1);
        req(OP_ADD, 0, 10, 1);
        req(OP_QUERY, 9, 63, 1);
        drain();

        set_vertex_count(1);
        req(OP_ADD, 0, 0, 0);
        req(OP_ADD, 0, 1, 0);
        req(OP_QUERY, 1, 0, 1);
        req(OP_QUERY, 0, 0, 1);
        drain();

        set_vertex_count(0);
        req(OP_QUERY, 0, 0, 1);
        req(OP_ADD, 1, 0, 0);
        drain();

        set_vertex_count(127);
        req(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < MAX_EDGES; i++)
            req(OP_ADD, $urandom_range(0, 7), $urandom_range(0, 7), 0);
        req(OP_ADD, 1, 2, 0);
        req(OP_QUERY, 0, 7, 1);
        req(OP_CLEAR, 0, 0, 0);
        drain();

        sent = 0;
        while (sent < 140)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                set_vertex_count($urandom_range(1, 64));
            else if (pick == 1)
                set_vertex_count($urandom_range(0, 127));
            else
                set_vertex_count(64);
            n = live_vertices();
            for (int s = 0; s < 4; s++)
            begin
                span = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(2, 16);
                req(OP_CLEAR, $urandom, $urandom, $urandom);
                ne = $urandom_range(0, 30);
                for (int e = 0; e < ne; e++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                    else
                        req(OP_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                            $urandom);
                end
                nq = $urandom_range(1, 4);
                for (int q = 0; q < nq; q++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        req(OP_QUERY, $urandom, $urandom, $urandom_range(0, 127));
                    else
                        req(OP_QUERY, $urandom_range(0, ((span < n) ? span : n) - 1),
                            $urandom_range(0, ((span < n) ? span : n) - 1),
                            $urandom_range(1, 4));
                end
                sent += ne + nq + 1;
            end
            drain();
        end

        drain();
        if (error_count == 0)
            $display("bfs_shortest_path_stride_top test passed");
        else
            $display("bfs_shortest_path_stride_top test failed");
        $finish;
    end

endmodule
